// File: sv/wawt_pkg.sv
// Shared types, codes and helpers of the weekly alarm window table.
// No dependencies; imported by wawt_mem, wawt_match and the top level.
`default_nettype none

package wawt_pkg;

    // Minute of day needs 11 bits: 31*60+63 plus a 63 minute window fits.
    localparam int MIN_W       = 11;
    localparam int NUM_DRAWERS = 8;

    localparam logic [5:0] DEF_TOLERANCE = 6'd15;

    // Item opcodes
    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_QUERY  = 2'd1;
    localparam logic [1:0] OP_DRAWER = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_ENTRIES   = 2'd0;
    localparam logic [1:0] CFG_TOLERANCE = 2'd1;
    localparam logic [1:0] CFG_ENABLE    = 2'd2;

    typedef struct packed {
        logic [6:0] days;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [2:0] compartment;
    } sched_t;

    typedef struct packed {
        logic fire;
        logic ack_hit;
    } match_t;

    typedef struct packed {
        logic rd_en;
        logic sched_we;
        logic ack_we;
    } mem_ctl_t;

    // hour*60 + minute as shift and subtract
    function automatic logic [MIN_W-1:0] minute_of_day(input logic [4:0] hour,
                                                       input logic [5:0] minute);
        logic [MIN_W-1:0] h;
        h = MIN_W'(hour);
        return (h << 6) - (h << 2) + MIN_W'(minute);
    endfunction

endpackage

`default_nettype wire

// File: sv/wawt_mem.sv
// Entry store: schedule memory and acknowledged-day memory, one write and
// one registered read port each. Depends on wawt_pkg.
`default_nettype none

module wawt_mem #(
    parameter int DEPTH = 16,
    parameter int IDX_W = 4
) (
    input  wire logic              aclk,
    input  wire wawt_pkg::mem_ctl_t ctl,
    input  wire logic [IDX_W-1:0]  rd_addr,
    input  wire logic [IDX_W-1:0]  wr_addr,
    input  wire wawt_pkg::sched_t  sched_wdata,
    input  wire logic [4:0]        ack_wdata,
    output wawt_pkg::sched_t       sched_rdata,
    output logic [4:0]             ack_rdata
);
    import wawt_pkg::*;

    sched_t     sched_mem [DEPTH];
    logic [4:0] ack_mem   [DEPTH];

    sched_t     sched_rdata_reg;
    logic [4:0] ack_rdata_reg;

    always_ff @(posedge aclk) begin
        if (ctl.sched_we) begin
            sched_mem[wr_addr] <= sched_wdata;
        end
        if (ctl.ack_we) begin
            ack_mem[wr_addr] <= ack_wdata;
        end
        if (ctl.rd_en) begin
            sched_rdata_reg <= sched_mem[rd_addr];
            ack_rdata_reg   <= ack_mem[rd_addr];
        end
    end

    assign sched_rdata = sched_rdata_reg;
    assign ack_rdata   = ack_rdata_reg;

endmodule

`default_nettype wire

// File: sv/wawt_match.sv
// Window test for one entry read from the store: weekday, minute window,
// acknowledged day and drawer bit. Depends on wawt_pkg.
`default_nettype none

module wawt_match (
    input  wire wawt_pkg::sched_t         entry,
    input  wire logic [4:0]               ack_day,
    input  wire logic [2:0]               now_weekday,
    input  wire logic [wawt_pkg::MIN_W-1:0] now_min,
    input  wire logic [4:0]               today,
    input  wire logic [5:0]               tolerance,
    input  wire logic [7:0]               drawer_mask,
    output wawt_pkg::match_t              result
);
    import wawt_pkg::*;

    logic [MIN_W-1:0] start_min;
    logic [MIN_W-1:0] end_min;
    logic [7:0]       days_ext;
    logic             in_win;
    logic             acked;

    always_comb begin
        start_min = minute_of_day(entry.hour, entry.minute);
        end_min   = start_min + MIN_W'(tolerance);
        // weekday code 7 lands on the padding bit and matches nothing
        days_ext  = {1'b0, entry.days};
        in_win    = days_ext[now_weekday] && (now_min >= start_min) && (now_min < end_min);
        acked     = (ack_day != 5'd0) && (ack_day == today);

        result.fire      = in_win && !acked;
        result.ack_hit   = in_win && (int'(entry.compartment) < NUM_DRAWERS)
                           && drawer_mask[entry.compartment];
    end

endmodule

`default_nettype wire

// File: sv/weekly_alarm_window_table.sv
// Weekly alarm window table: top level with walk sequencer and result register.
// Depends on wawt_pkg, wawt_mem and wawt_match.
//
// Input channel (s_*): one beat per item. A write item loads one table slot
// as it is accepted. A query or drawer item walks the entries in use (none
// while the table is disabled), one entry per cycle unless a stalled receiver
// holds it, through the single read port of the entry store. The next item
// is taken once the walk is over and, for a query, once its final beat is
// registered; a drawer item writes acknowledged days back as it walks.
// Result channel (m_*): a query delivers one beat per firing entry, the final
// one flagged by m_last_result; with nothing firing it delivers one empty
// beat with m_last_result set. Write and drawer items deliver nothing.
// Results sit in an output register: the next item is taken while the last
// beat of a query still waits. When the receiver stalls, the walk holds on a
// firing entry until the register frees up, and the closing beat waits too.
// Configuration (cfg_*): always ready; write it only while the block is idle.
// Reset clears the registers to 0 entries, 15 minutes, table disabled; the
// table contents stay undefined until written.
`default_nettype none

module weekly_alarm_window_table #(
    parameter int MAX_ENTRIES = 16
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,

    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [1:0] s_opcode,
    input  wire logic [3:0] s_entry_index,
    input  wire logic [6:0] s_entry_days,
    input  wire logic [4:0] s_entry_hour,
    input  wire logic [5:0] s_entry_minute,
    input  wire logic [2:0] s_entry_compartment,
    input  wire logic [4:0] s_entry_last_day,
    input  wire logic [2:0] s_now_weekday,
    input  wire logic [4:0] s_now_hour,
    input  wire logic [5:0] s_now_minute,
    input  wire logic [4:0] s_now_day_of_month,
    input  wire logic [7:0] s_drawer_mask,

    output logic            m_valid,
    input  wire logic       m_ready,
    output logic            m_alert_valid,
    output logic [2:0]      m_alert_compartment,
    output logic            m_last_result,

    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [1:0] cfg_index,
    input  wire logic [5:0] cfg_data
);
    import wawt_pkg::*;

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_WALK = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic               is_query_reg, is_query_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   rd_cnt_reg, rd_cnt_next;
    logic               ev_vld_reg, ev_vld_next;
    logic [IDX_W-1:0]   ev_idx_reg, ev_idx_next;
    logic               hold_vld_reg, hold_vld_next;
    logic [2:0]         hold_comp_reg, hold_comp_next;
    logic [4:0]         entries_reg, entries_next;
    logic [5:0]         tol_reg, tol_next;
    logic               enable_reg, enable_next;
    logic               m_valid_reg, m_valid_next;
    logic               m_alert_reg, m_alert_next;
    logic [2:0]         m_comp_reg, m_comp_next;
    logic               m_last_reg, m_last_next;

    logic [2:0]         wday_reg, wday_next;
    logic [MIN_W-1:0]   now_min_reg, now_min_next;
    logic [4:0]         today_reg, today_next;
    logic [7:0]         mask_reg, mask_next;

    logic               in_acc;
    logic               out_free;
    logic [CNT_W-1:0]   live_cnt;
    logic               slot_ok;
    logic               stall;
    logic               issue;
    logic               eval_go;
    logic               walk_end;
    logic               push_mid;
    logic               push_final;

    mem_ctl_t           mem_ctl;
    logic [IDX_W-1:0]   wr_addr;
    sched_t             sched_wdata;
    logic [4:0]         ack_wdata;
    sched_t             sched_rdata;
    logic [4:0]         ack_rdata;
    match_t             mt;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_acc    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;

    assign live_cnt = (int'(entries_reg) > MAX_ENTRIES) ? CNT_W'(MAX_ENTRIES)
                                                        : CNT_W'(entries_reg);
    assign slot_ok  = int'(s_entry_index) < MAX_ENTRIES;

    // Hold the entry in evaluation while a result cannot be handed on.
    assign stall      = ev_vld_reg && is_query_reg && mt.fire && hold_vld_reg && !out_free;
    assign issue      = (state_reg == ST_WALK) && (rd_cnt_reg < count_reg) && !stall;
    assign eval_go    = ev_vld_reg && !stall;
    assign walk_end   = (state_reg == ST_WALK) && (rd_cnt_reg == count_reg) && !ev_vld_reg;
    assign push_mid   = eval_go && is_query_reg && mt.fire && hold_vld_reg;
    assign push_final = (state_reg == ST_DONE) && out_free;

    always_comb begin
        mem_ctl.rd_en    = issue;
        mem_ctl.sched_we = in_acc && (s_opcode == OP_WRITE) && slot_ok;
        mem_ctl.ack_we   = (in_acc && (s_opcode == OP_WRITE) && slot_ok)
                           || (eval_go && !is_query_reg && mt.ack_hit);
        wr_addr          = (state_reg == ST_IDLE) ? IDX_W'(s_entry_index) : ev_idx_reg;
        ack_wdata        = (state_reg == ST_IDLE) ? s_entry_last_day : today_reg;
        sched_wdata.days        = s_entry_days;
        sched_wdata.hour        = s_entry_hour;
        sched_wdata.minute      = s_entry_minute;
        sched_wdata.compartment = s_entry_compartment;
    end

    wawt_mem #(
        .DEPTH (MAX_ENTRIES),
        .IDX_W (IDX_W)
    ) u_mem (
        .aclk        (aclk),
        .ctl         (mem_ctl),
        .rd_addr     (rd_cnt_reg[IDX_W-1:0]),
        .wr_addr     (wr_addr),
        .sched_wdata (sched_wdata),
        .ack_wdata   (ack_wdata),
        .sched_rdata (sched_rdata),
        .ack_rdata   (ack_rdata)
    );

    wawt_match u_match (
        .entry       (sched_rdata),
        .ack_day     (ack_rdata),
        .now_weekday (wday_reg),
        .now_min     (now_min_reg),
        .today       (today_reg),
        .tolerance   (tol_reg),
        .drawer_mask (mask_reg),
        .result      (mt)
    );

    always_comb begin
        state_next     = state_reg;
        is_query_next  = is_query_reg;
        count_next     = count_reg;
        rd_cnt_next    = rd_cnt_reg;
        ev_vld_next    = issue || (ev_vld_reg && stall);
        ev_idx_next    = issue ? rd_cnt_reg[IDX_W-1:0] : ev_idx_reg;
        hold_vld_next  = hold_vld_reg;
        hold_comp_next = hold_comp_reg;
        entries_next   = entries_reg;
        tol_next       = tol_reg;
        enable_next    = enable_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_alert_next   = m_alert_reg;
        m_comp_next    = m_comp_reg;
        m_last_next    = m_last_reg;
        wday_next      = wday_reg;
        now_min_next   = now_min_reg;
        today_next     = today_reg;
        mask_next      = mask_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc && (s_opcode == OP_QUERY || s_opcode == OP_DRAWER)) begin
                    state_next    = ST_WALK;
                    is_query_next = (s_opcode == OP_QUERY);
                    count_next    = enable_reg ? live_cnt : '0;
                    rd_cnt_next   = '0;
                    hold_vld_next = 1'b0;
                    wday_next     = s_now_weekday;
                    now_min_next  = minute_of_day(s_now_hour, s_now_minute);
                    today_next    = s_now_day_of_month;
                    mask_next     = s_drawer_mask;
                end
            end
            ST_WALK: begin
                if (issue) begin
                    rd_cnt_next = rd_cnt_reg + CNT_W'(1);
                end
                if (walk_end) begin
                    state_next = is_query_reg ? ST_DONE : ST_IDLE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Keep one firing entry back so the final beat can carry the last flag.
        if (eval_go && is_query_reg && mt.fire) begin
            hold_vld_next  = 1'b1;
            hold_comp_next = sched_rdata.compartment;
        end

        if (push_mid) begin
            m_valid_next = 1'b1;
            m_alert_next = 1'b1;
            m_comp_next  = hold_comp_reg;
            m_last_next  = 1'b0;
        end else if (push_final) begin
            m_valid_next = 1'b1;
            m_alert_next = hold_vld_reg;
            m_comp_next  = hold_vld_reg ? hold_comp_reg : 3'd0;
            m_last_next  = 1'b1;
        end

        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_ENTRIES:   entries_next = cfg_data[4:0];
                CFG_TOLERANCE: tol_next     = cfg_data;
                CFG_ENABLE:    enable_next  = cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            is_query_reg <= 1'b0;
            count_reg    <= '0;
            rd_cnt_reg   <= '0;
            ev_vld_reg   <= 1'b0;
            hold_vld_reg <= 1'b0;
            entries_reg  <= 5'd0;
            tol_reg      <= DEF_TOLERANCE;
            enable_reg   <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            is_query_reg <= is_query_next;
            count_reg    <= count_next;
            rd_cnt_reg   <= rd_cnt_next;
            ev_vld_reg   <= ev_vld_next;
            hold_vld_reg <= hold_vld_next;
            entries_reg  <= entries_next;
            tol_reg      <= tol_next;
            enable_reg   <= enable_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ev_idx_reg    <= ev_idx_next;
        hold_comp_reg <= hold_comp_next;
        m_alert_reg   <= m_alert_next;
        m_comp_reg    <= m_comp_next;
        m_last_reg    <= m_last_next;
        wday_reg      <= wday_next;
        now_min_reg   <= now_min_next;
        today_reg     <= today_next;
        mask_reg      <= mask_next;
    end

    assign m_valid             = m_valid_reg;
    assign m_alert_valid       = m_alert_reg;
    assign m_alert_compartment = m_comp_reg;
    assign m_last_result       = m_last_reg;

endmodule

`default_nettype wire

// File: sv/wawt_checker.sv
// Port-level checks of the weekly alarm window table, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module wawt_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_ready,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic       m_alert_valid,
    input wire logic [2:0] m_alert_compartment,
    input wire logic       m_last_result
);

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_alert_valid)
            && $stable(m_alert_compartment) && $stable(m_last_result))
        else $error("result beat changed while stalled");

    // An empty result only closes a query.
    a_empty_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_alert_valid |-> m_last_result)
        else $error("empty result without last flag");

    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_alert_valid |-> m_alert_compartment == 3'd0)
        else $error("empty result carries a compartment");

    // Reset drops the result and reopens the input.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("block not idle after reset");

endmodule

bind weekly_alarm_window_table wawt_checker u_wawt_checker (.*);

`default_nettype wire

// File: verif/weekly_alarm_window_table_tb.sv
// Self-checking testbench for weekly_alarm_window_table: directed table, then random beats.
// Depends on wawt_pkg and the block's RTL; predicts alert beats from its own copy of the table.
`timescale 1ns / 1ps

module weekly_alarm_window_table_tb;
    import wawt_pkg::*;

    localparam logic [1:0] OP_UNUSED  = 2'd3;
    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam int SLOTS        = 16;
    localparam int HOLD_CYCLES  = 30;
    localparam int QUIET_LIMIT  = 4000;

    typedef struct packed {
        logic [1:0] opcode;
        logic [3:0] entry_index;
        logic [6:0] entry_days;
        logic [4:0] entry_hour;
        logic [5:0] entry_minute;
        logic [2:0] entry_compartment;
        logic [4:0] entry_last_day;
        logic [2:0] now_weekday;
        logic [4:0] now_hour;
        logic [5:0] now_minute;
        logic [4:0] now_day_of_month;
        logic [7:0] drawer_mask;
    } alarm_beat_t;

    typedef struct packed {
        logic       active;
        logic [2:0] compartment;
        logic       last;
    } alert_t;

    typedef enum logic {ROW_BEAT, ROW_REG} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        alarm_beat_t beat;
        logic [1:0]  reg_idx;
        logic [5:0]  reg_val;
        bit          fixed;
        alert_t      want;
    } plan_row_t;

    localparam alert_t NO_ALERT = '{active: 1'b0, compartment: 3'd0, last: 1'b1};

    logic       aclk    = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic [1:0] s_opcode = '0;
    logic [3:0] s_entry_index = '0;
    logic [6:0] s_entry_days = '0;
    logic [4:0] s_entry_hour = '0;
    logic [5:0] s_entry_minute = '0;
    logic [2:0] s_entry_compartment = '0;
    logic [4:0] s_entry_last_day = '0;
    logic [2:0] s_now_weekday = '0;
    logic [4:0] s_now_hour = '0;
    logic [5:0] s_now_minute = '0;
    logic [4:0] s_now_day_of_month = '0;
    logic [7:0] s_drawer_mask = '0;
    logic       m_ready = 1'b0;
    logic       cfg_valid = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [5:0] cfg_data = '0;

    logic       s_ready;
    logic       m_valid;
    logic       m_alert_valid;
    logic [2:0] m_alert_compartment;
    logic       m_last_result;
    logic       cfg_ready;

    weekly_alarm_window_table #(.MAX_ENTRIES(SLOTS)) dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_opcode            (s_opcode),
        .s_entry_index       (s_entry_index),
        .s_entry_days        (s_entry_days),
        .s_entry_hour        (s_entry_hour),
        .s_entry_minute      (s_entry_minute),
        .s_entry_compartment (s_entry_compartment),
        .s_entry_last_day    (s_entry_last_day),
        .s_now_weekday       (s_now_weekday),
        .s_now_hour          (s_now_hour),
        .s_now_minute        (s_now_minute),
        .s_now_day_of_month  (s_now_day_of_month),
        .s_drawer_mask       (s_drawer_mask),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_alert_valid       (m_alert_valid),
        .m_alert_compartment (m_alert_compartment),
        .m_last_result       (m_last_result),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Mirror of the alarm table and its registers
    logic [6:0] slot_days   [SLOTS];
    logic [4:0] slot_hour   [SLOTS];
    logic [5:0] slot_minute [SLOTS];
    logic [2:0] slot_comp   [SLOTS];
    logic [4:0] slot_ack    [SLOTS];
    logic [4:0] reg_entries   = 5'd0;
    logic [5:0] reg_tolerance = DEF_TOLERANCE;
    logic       reg_enable    = 1'b0;

    alert_t alerts_due[$];
    int     mismatch_count = 0;
    int     idle_pct  = 0;
    int     stall_pct = 0;
    int     quiet_cycles = 0;
    plan_row_t plan[$];

    task automatic queue_alert(input alert_t a);
        alerts_due = {alerts_due, a};
    endtask

    task automatic add_row(input plan_row_t r);
        plan = {plan, r};
    endtask

    function automatic int live_slots();
        return (int'(reg_entries) > SLOTS) ? SLOTS : int'(reg_entries);
    endfunction

    function automatic int start_minute(int s);
        return int'(slot_hour[s]) * 60 + int'(slot_minute[s]);
    endfunction

    function automatic bit slot_in_window(int s, logic [2:0] wday, int now_min);
        int start;
        if (wday > 3'd6) return 1'b0;
        if (!slot_days[s][wday]) return 1'b0;
        start = start_minute(s);
        return (now_min >= start) && (now_min < start + int'(reg_tolerance));
    endfunction

    // Update the mirror for one accepted beat and queue the alert beats it causes
    task automatic predict_alerts(input alarm_beat_t b, input bit fixed, input alert_t want);
        int         now_min;
        logic [2:0] comps[$];
        now_min = int'(b.now_hour) * 60 + int'(b.now_minute);
        case (b.opcode)
            OP_WRITE: begin
                slot_days[b.entry_index]   = b.entry_days;
                slot_hour[b.entry_index]   = b.entry_hour;
                slot_minute[b.entry_index] = b.entry_minute;
                slot_comp[b.entry_index]   = b.entry_compartment;
                slot_ack[b.entry_index]    = b.entry_last_day;
            end
            OP_QUERY: begin
                if (fixed) begin
                    queue_alert(want);
                end else begin
                    if (reg_enable) begin
                        for (int i = 0; i < live_slots(); i++) begin
                            if (slot_in_window(i, b.now_weekday, now_min) &&
                                !(slot_ack[i] != 5'd0 && slot_ack[i] == b.now_day_of_month))
                                comps = {comps, slot_comp[i]};
                        end
                    end
                    if (comps.size() == 0) begin
                        queue_alert(NO_ALERT);
                    end else begin
                        for (int j = 0; j < comps.size(); j++)
                            queue_alert('{active: 1'b1, compartment: comps[j],
                                          last: (j == comps.size() - 1)});
                    end
                end
            end
            OP_DRAWER: begin
                if (reg_enable) begin
                    for (int i = 0; i < live_slots(); i++) begin
                        if (int'(slot_comp[i]) < NUM_DRAWERS && b.drawer_mask[slot_comp[i]] &&
                            slot_in_window(i, b.now_weekday, now_min))
                            slot_ack[i] = b.now_day_of_month;
                    end
                end
            end
            default: ;
        endcase
    endtask

    function automatic alarm_beat_t noise_beat();
        alarm_beat_t b;
        b.opcode            = 2'($urandom);
        b.entry_index       = 4'($urandom);
        b.entry_days        = 7'($urandom);
        b.entry_hour        = 5'($urandom);
        b.entry_minute      = 6'($urandom);
        b.entry_compartment = 3'($urandom);
        b.entry_last_day    = 5'($urandom);
        b.now_weekday       = 3'($urandom);
        b.now_hour          = 5'($urandom);
        b.now_minute        = 6'($urandom);
        b.now_day_of_month  = 5'($urandom);
        b.drawer_mask       = 8'($urandom);
        return b;
    endfunction

    function automatic alarm_beat_t write_beat(logic [3:0] idx, logic [6:0] days,
                                               logic [4:0] hour, logic [5:0] minute,
                                               logic [2:0] comp, logic [4:0] last_day);
        alarm_beat_t b;
        b = noise_beat();
        b.opcode            = OP_WRITE;
        b.entry_index       = idx;
        b.entry_days        = days;
        b.entry_hour        = hour;
        b.entry_minute      = minute;
        b.entry_compartment = comp;
        b.entry_last_day    = last_day;
        return b;
    endfunction

    function automatic alarm_beat_t clock_beat(logic [1:0] op, logic [2:0] wday,
                                               logic [4:0] hour, logic [5:0] minute,
                                               logic [4:0] dom, logic [7:0] mask);
        alarm_beat_t b;
        b = noise_beat();
        b.opcode           = op;
        b.now_weekday      = wday;
        b.now_hour         = hour;
        b.now_minute       = minute;
        b.now_day_of_month = dom;
        b.drawer_mask      = mask;
        return b;
    endfunction

    function automatic plan_row_t beat_row(alarm_beat_t b);
        plan_row_t r;
        r = '{kind: ROW_BEAT, beat: b, reg_idx: '0, reg_val: '0, fixed: 1'b0, want: NO_ALERT};
        return r;
    endfunction

    function automatic plan_row_t fixed_row(alarm_beat_t b, alert_t want);
        plan_row_t r;
        r = '{kind: ROW_BEAT, beat: b, reg_idx: '0, reg_val: '0, fixed: 1'b1, want: want};
        return r;
    endfunction

    function automatic plan_row_t reg_row(logic [1:0] idx, logic [5:0] val);
        plan_row_t r;
        r = '{kind: ROW_REG, beat: '0, reg_idx: idx, reg_val: val, fixed: 1'b0, want: NO_ALERT};
        return r;
    endfunction

    // Mostly aim queries and drawer beats at the window of a slot in use
    function automatic alarm_beat_t random_beat();
        alarm_beat_t b;
        int pick, s, now_min, wd;
        b = noise_beat();
        pick = $urandom_range(99);
        if (pick < 25) begin
            b.opcode = OP_WRITE;
            if ($urandom_range(99) < 80) b.entry_hour = 5'($urandom_range(7, 9));
            if ($urandom_range(99) < 90) b.entry_minute = 6'($urandom_range(0, 59));
            if ($urandom_range(9) == 0) b.entry_days = 7'h7F;
            return b;
        end
        if (pick >= 95) begin
            b.opcode = OP_UNUSED;
            return b;
        end
        b.opcode = (pick < 72) ? OP_QUERY : OP_DRAWER;
        if (live_slots() > 0 && $urandom_range(99) < 80) begin
            s = $urandom_range(0, live_slots() - 1);
            now_min = start_minute(s) + $urandom_range(0, int'(reg_tolerance) + 1);
            if ($urandom_range(9) == 0) now_min = now_min - 1;
            if (now_min < 0) now_min = 0;
            if (now_min / 60 <= 31) begin
                b.now_hour   = 5'(now_min / 60);
                b.now_minute = 6'(now_min % 60);
            end
            if (slot_days[s] != 7'd0 && $urandom_range(9) != 0) begin
                do wd = $urandom_range(0, 6); while (!slot_days[s][wd]);
                b.now_weekday = 3'(wd);
            end
            if ($urandom_range(1) == 1) b.now_day_of_month = slot_ack[s];
            case ($urandom_range(3))
                0: b.drawer_mask = 8'hFF;
                1: b.drawer_mask = 8'd1 << slot_comp[s];
                default: ;
            endcase
        end
        return b;
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("%0t: mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic send_beat(input alarm_beat_t b, input bit fixed, input alert_t want);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid             <= 1'b1;
        s_opcode            <= b.opcode;
        s_entry_index       <= b.entry_index;
        s_entry_days        <= b.entry_days;
        s_entry_hour        <= b.entry_hour;
        s_entry_minute      <= b.entry_minute;
        s_entry_compartment <= b.entry_compartment;
        s_entry_last_day    <= b.entry_last_day;
        s_now_weekday       <= b.now_weekday;
        s_now_hour          <= b.now_hour;
        s_now_minute        <= b.now_minute;
        s_now_day_of_month  <= b.now_day_of_month;
        s_drawer_mask       <= b.drawer_mask;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_alerts(b, fixed, want);
    endtask

    // Drop valid in the step of the last acceptance, then wait out every alert beat
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (alerts_due.size() != 0) @(posedge aclk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [5:0] val);
        while (alerts_due.size() != 0) @(posedge aclk);
        // a drawer beat may still be walking the table
        repeat (HOLD_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (idx == CFG_ENTRIES) reg_entries = val[4:0];
        else if (idx == CFG_TOLERANCE) reg_tolerance = val;
        else if (idx == CFG_ENABLE) reg_enable = val[0];
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic run_segment(input int send_idle, input int rx_stall, input logic [5:0] entries,
                               input logic [5:0] tolerance, input logic enable, input int count);
        drain();
        write_register(CFG_ENTRIES, entries);
        write_register(CFG_TOLERANCE, tolerance);
        write_register(CFG_ENABLE, {5'd0, enable});
        idle_pct  = send_idle;
        stall_pct = rx_stall;
        for (int k = 0; k < count; k++) begin
            // hold the sender once per segment until every alert beat is home
            if (k == count / 2) drain();
            send_beat(random_beat(), 1'b0, NO_ALERT);
        end
    endtask

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin : result_check
        alert_t want;
        if (aresetn && m_valid && m_ready) begin
            if (alerts_due.size() == 0) begin
                flag_mismatch($sformatf("unexpected beat alert=%0d comp=%0d last=%0d",
                                        m_alert_valid, m_alert_compartment, m_last_result));
            end else begin
                want = alerts_due.pop_front();
                if (m_alert_valid !== want.active)
                    flag_mismatch($sformatf("alert_valid %0d, expected %0d",
                                            m_alert_valid, want.active));
                if (m_alert_compartment !== want.compartment)
                    flag_mismatch($sformatf("alert_compartment %0d, expected %0d",
                                            m_alert_compartment, want.compartment));
                if (m_last_result !== want.last)
                    flag_mismatch($sformatf("last_result %0d, expected %0d",
                                            m_last_result, want.last));
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("weekly_alarm_window_table_tb: errors");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            slot_days[i]   = '0;
            slot_hour[i]   = '0;
            slot_minute[i] = '0;
            slot_comp[i]   = '0;
            slot_ack[i]    = '0;
        end

        // Slot 0 fires late on every day, slot 1 early Sunday, slot 15 past any real time
        add_row(fixed_row(clock_beat(OP_QUERY, 3'd0, 5'd0, 6'd0, 5'd1, 8'h00), NO_ALERT));
        add_row(beat_row(clock_beat(OP_DRAWER, 3'd6, 5'd23, 6'd59, 5'd31, 8'hFF)));
        add_row(reg_row(CFG_ENABLE, 6'd1));
        add_row(fixed_row(clock_beat(OP_QUERY, 3'd6, 5'd23, 6'd59, 5'd1, 8'h00), NO_ALERT));
        add_row(reg_row(CFG_ENTRIES, 6'd31));
        add_row(beat_row(write_beat(4'd0, 7'h7F, 5'd23, 6'd59, 3'd7, 5'd0)));
        add_row(beat_row(write_beat(4'd1, 7'h01, 5'd0, 6'd0, 3'd0, 5'd31)));
        add_row(beat_row(write_beat(4'd15, 7'h40, 5'd31, 6'd63, 3'd3, 5'd5)));
        add_row(fixed_row(clock_beat(OP_QUERY, 3'd6, 5'd23, 6'd59, 5'd1, 8'h00),
                          '{active: 1'b1, compartment: 3'd7, last: 1'b1}));
        add_row(fixed_row(clock_beat(OP_QUERY, 3'd7, 5'd23, 6'd59, 5'd1, 8'hFF), NO_ALERT));
        add_row(fixed_row(clock_beat(OP_QUERY, 3'd6, 5'd31, 6'd63, 5'd5, 8'h00), NO_ALERT));
        add_row(beat_row(clock_beat(OP_QUERY, 3'd6, 5'd31, 6'd63, 5'd0, 8'h00)));
        add_row(beat_row(clock_beat(OP_DRAWER, 3'd6, 5'd31, 6'd63, 5'd0, 8'h08)));
        add_row(beat_row(clock_beat(OP_QUERY, 3'd6, 5'd31, 6'd63, 5'd5, 8'h00)));
        add_row(reg_row(CFG_TOLERANCE, 6'd0));
        add_row(fixed_row(clock_beat(OP_QUERY, 3'd6, 5'd23, 6'd59, 5'd1, 8'h00), NO_ALERT));
        add_row(reg_row(CFG_TOLERANCE, 6'd63));
        add_row(beat_row(clock_beat(OP_QUERY, 3'd0, 5'd1, 6'd2, 5'd31, 8'h00)));
        add_row(beat_row(clock_beat(OP_DRAWER, 3'd0, 5'd1, 6'd2, 5'd20, 8'hFF)));
        add_row(beat_row(clock_beat(OP_QUERY, 3'd0, 5'd1, 6'd2, 5'd21, 8'h00)));
        add_row(reg_row(CFG_TOLERANCE, 6'd1));
        add_row(fixed_row(clock_beat(OP_QUERY, 3'd6, 5'd23, 6'd59, 5'd9, 8'h00),
                          '{active: 1'b1, compartment: 3'd7, last: 1'b1}));
        add_row(beat_row(clock_beat(OP_DRAWER, 3'd6, 5'd23, 6'd59, 5'd9, 8'h7F)));
        add_row(beat_row(clock_beat(OP_QUERY, 3'd6, 5'd23, 6'd59, 5'd9, 8'h00)));
        add_row(beat_row(clock_beat(OP_UNUSED, 3'd6, 5'd23, 6'd59, 5'd9, 8'hFF)));
        add_row(reg_row(CFG_UNUSED, 6'h3F));
        add_row(beat_row(clock_beat(OP_QUERY, 3'd6, 5'd23, 6'd59, 5'd9, 8'h00)));

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Load every slot with a mask that never matches, so no walk reads an unwritten slot
        for (int i = 0; i < SLOTS; i++)
            send_beat(write_beat(4'(i), 7'd0, 5'($urandom), 6'($urandom), 3'(i), 5'd0),
                      1'b0, NO_ALERT);

        foreach (plan[r]) begin
            if (plan[r].kind == ROW_REG) begin
                drain();
                write_register(plan[r].reg_idx, plan[r].reg_val);
            end else begin
                send_beat(plan[r].beat, plan[r].fixed, plan[r].want);
            end
        end

        run_segment(0, 0, 6'd16, 6'd60, 1'b1, 80);
        run_segment(52, 0, 6'($urandom_range(1, 15)), 6'($urandom_range(1, 60)), 1'b1, 80);
        run_segment(0, 52, 6'd31, 6'd63, 1'b1, 80);
        run_segment(29, 29, 6'($urandom_range(0, 31)), 6'($urandom_range(1, 63)), 1'b0, 20);
        run_segment(29, 29, 6'd16, 6'd15, 1'b1, 73);

        drain();
        repeat (HOLD_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("weekly_alarm_window_table_tb: clean");
        end else begin
            $display("weekly_alarm_window_table_tb: errors");
        end
        $finish;
    end

endmodule
